[hw/rtl/srsw_pkg.sv]
// Shared types and codes for the selective-repeat sender window.
package srsw_pkg;
  localparam int WINDOW = 16;

  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NOTHING = 2'd0,
    KIND_NEW     = 2'd1,
    KIND_RESEND  = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_SENT  = 2'd1,
    SLOT_ACKED = 2'd2
  } slot_t;

  localparam logic [0:0] REG_PACKET_TOTAL    = 1'b0;
  localparam logic [0:0] REG_INITIAL_TIMEOUT = 1'b1;
  localparam logic [31:0] TIMEOUT_MIN = 32'd5;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  resends;
  } entry_t;

  // Operation applied to the whole queue chain.
  typedef enum logic [1:0] {
    QOP_HOLD   = 2'd0,
    QOP_APPEND = 2'd1,
    QOP_DROP   = 2'd2,
    QOP_ROTATE = 2'd3
  } qop_t;

  typedef struct packed {
    qop_t        op;
    logic [15:0] match_seq;
    entry_t      tail;
  } qctl_t;
endpackage

[hw/rtl/srsw_cell.sv]
// One cell of the timeout queue chain: holds one entry, shifts toward the head.
module srsw_cell (
  input  logic             clk,
  input  logic             rst,
  input  srsw_pkg::qctl_t  ctl,
  input  logic             is_tail,
  input  logic             occupied,
  input  logic             drop_before_in,
  input  srsw_pkg::entry_t right_entry,
  input  logic             right_occupied,
  output logic             drop_before_out,
  output srsw_pkg::entry_t entry
);
  import srsw_pkg::*;

  logic hit;

  assign hit = occupied && (entry.seq == ctl.match_seq);
  assign drop_before_out = drop_before_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      unique case (ctl.op)
        QOP_APPEND: begin
          if (is_tail) entry <= ctl.tail;
        end
        QOP_DROP: begin
          if (drop_before_out) entry <= right_entry;
        end
        QOP_ROTATE: begin
          if (is_tail) entry <= ctl.tail;
          else if (right_occupied) entry <= right_entry;
        end
        default: begin
        end
      endcase
    end
  end
endmodule

[hw/rtl/srsw_queue.sv]
// Timeout queue built as a chain of cells with a fill count.
module srsw_queue #(
  parameter int WINDOW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srsw_pkg::qctl_t          ctl,
  output srsw_pkg::entry_t         head,
  output logic                     hit_any,
  output srsw_pkg::entry_t         hit_entry,
  output logic [$clog2(WINDOW+1)-1:0] count
);
  import srsw_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);

  entry_t entries [WINDOW+1];
  logic   chain   [WINDOW+1];
  logic [CW-1:0] count_next;

  assign chain[0] = 1'b0;
  assign entries[WINDOW] = '0;
  assign head = entries[0];
  assign hit_any = chain[WINDOW];

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (!chain[i] && chain[i+1]) hit_entry = entries[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      logic occ, tail_here, occ_right;
      assign occ = CW'(g) < count;
      assign occ_right = CW'(g + 1) < count;
      assign tail_here = (ctl.op == QOP_APPEND) ? (CW'(g) == count)
                                                : (CW'(g + 1) == count);
      srsw_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .ctl            (ctl),
        .is_tail        (tail_here),
        .occupied       (occ),
        .drop_before_in (chain[g]),
        .right_entry    (entries[g+1]),
        .right_occupied (occ_right),
        .drop_before_out(chain[g+1]),
        .entry          (entries[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.op == QOP_APPEND) count_next = count + CW'(1);
    else if (ctl.op == QOP_DROP && hit_any) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count_next;
  end
endmodule

[hw/rtl/selective_repeat_sender_window.sv]
// Top level of the selective-repeat sender window.
// Channels: input requests (action, ack_seq, ack_resends, now_ms) on in_valid/in_ready,
// one result per request on out_valid/out_ready, register writes on cfg_valid/cfg_ready.
// Register 0 is packet_total, register 1 the initial timeout (clamped to at least 5, loaded at once).
// A send appends to a chain of WINDOW queue cells; an acknowledgement drops the matching
// cell and shifts the rest toward the head in one pass, a time check rotates the head.
// Steps: a send, a time check or a stray request passes through EXEC, then OUT, where
// its result is loaded. An accepted acknowledgement goes from EXEC to WALK, which frees
// the window base one acknowledged slot per cycle, up to WINDOW slots, then goes to OUT;
// one holding the timing sample passes MUL (multiply) and CLAMP before the walk.
// One request is worked on at a time; the next can be taken once the block is back in
// IDLE after its result is loaded, unless a register write is waiting, as writes win.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls with a result held, the next request is worked on and
// the block waits with it until the output register frees.
// Reset clears all control state, sets packet_total to 1 and the timeout to 1000;
// there is no clearing pass.
module selective_repeat_sender_window (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] ack_seq,
  input  logic [7:0]  ack_resends,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] tx_seq,
  output logic [7:0]  tx_resends,
  output logic [15:0] base_now,
  output logic [4:0]  in_flight,
  output logic        done_res,
  output logic [31:0] timeout_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import srsw_pkg::*;

  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_CLAMP, ST_WALK, ST_OUT
  } state_t;

  state_t state;
  logic [1:0]  r_action;
  logic [15:0] r_seq;
  logic [7:0]  r_res;
  logic [31:0] r_now;
  logic [15:0] packet_total;
  logic [31:0] current_timeout;
  slot_t       slot_status [WINDOW];
  logic [15:0] next_seq, base_seq, sample_seq;
  logic [CW-1:0] free_slots;
  logic        sample_valid, sending_finished;
  logic [CW-1:0] steps;
  logic signed [9:0]  factor;
  logic [31:0] rtt;
  logic signed [42:0] product;
  logic [1:0]  res_kind;
  logic [15:0] res_seq;
  logic [7:0]  res_res;

  qctl_t  ctl;
  entry_t head, hit_entry;
  logic   hit_any;
  logic [CW-1:0] count;

  srsw_queue #(.WINDOW(WINDOW)) u_queue (
    .clk(clk), .rst(rst), .ctl(ctl), .head(head),
    .hit_any(hit_any), .hit_entry(hit_entry), .count(count)
  );

  logic [15:0] eff_total;
  logic [16:0] sent_count;
  logic [SW-1:0] ack_slot, base_slot;
  logic send_ok, ack_ok, check_ok;
  logic [31:0] head_age;
  logic [7:0]  head_res_inc;
  logic signed [44:0] sum;

  assign eff_total = (packet_total == 16'd0) ? 16'd1 : packet_total;
  assign sent_count = {1'b0, next_seq} + {16'd0, sending_finished};
  assign ack_slot = r_seq[SW-1:0];
  assign base_slot = base_seq[SW-1:0];
  assign send_ok = (free_slots != '0) && !sending_finished && (count < CW'(WINDOW));
  assign ack_ok = (r_seq >= base_seq) && ({1'b0, r_seq} < sent_count)
                  && (slot_status[ack_slot] == SLOT_SENT);
  assign head_age = r_now - head.stamp;
  assign check_ok = (count != '0) && (head_age >= current_timeout);
  assign head_res_inc = (head.resends == 8'hFF) ? 8'hFF : head.resends + 8'd1;
  assign sum = 45'(product) + $signed({13'd0, rtt});

  always_comb begin
    ctl = '0;
    ctl.match_seq = r_seq;
    if (state == ST_EXEC) begin
      unique case (r_action)
        ACT_SEND: if (send_ok) begin
          ctl.op = QOP_APPEND;
          ctl.tail = '{seq: next_seq, stamp: r_now, resends: 8'd0};
        end
        ACT_ACK: if (ack_ok) ctl.op = QOP_DROP;
        ACT_CHECK: if (check_ok) begin
          ctl.op = QOP_ROTATE;
          ctl.tail = '{seq: head.seq, stamp: r_now, resends: head_res_inc};
        end
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      packet_total <= 16'd1;
      current_timeout <= 32'd1000;
      for (int i = 0; i < WINDOW; i++) slot_status[i] <= SLOT_FREE;
      next_seq <= '0;
      base_seq <= '0;
      sample_seq <= '0;
      free_slots <= CW'(WINDOW);
      sample_valid <= 1'b0;
      sending_finished <= 1'b0;
      steps <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_PACKET_TOTAL) packet_total <= cfg_data;
            else current_timeout <= ({16'd0, cfg_data} < TIMEOUT_MIN) ? TIMEOUT_MIN
                                                                       : {16'd0, cfg_data};
          end else if (in_valid) begin
            r_action <= action;
            r_seq <= ack_seq;
            r_res <= ack_resends;
            r_now <= now_ms;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_kind <= KIND_NOTHING;
          res_seq <= '0;
          res_res <= '0;
          state <= ST_OUT;
          unique case (r_action)
            ACT_SEND: begin
              if (send_ok) begin
                slot_status[next_seq[SW-1:0]] <= SLOT_SENT;
                if (!sample_valid) begin
                  sample_seq <= next_seq;
                  sample_valid <= 1'b1;
                end
                free_slots <= free_slots - CW'(1);
                if ({1'b0, next_seq} + 17'd1 >= {1'b0, eff_total}) sending_finished <= 1'b1;
                else next_seq <= next_seq + 16'd1;
                res_kind <= KIND_NEW;
                res_seq <= next_seq;
              end else begin
                res_kind <= KIND_REFUSED;
              end
            end
            ACT_ACK: begin
              if (ack_ok) begin
                slot_status[ack_slot] <= SLOT_ACKED;
                steps <= '0;
                state <= ST_WALK;
                if (hit_any && sample_valid && sample_seq == r_seq) begin
                  sample_valid <= 1'b0;
                  factor <= $signed({2'b0, hit_entry.resends}) - $signed({2'b0, r_res});
                  rtt <= r_now - hit_entry.stamp;
                  state <= ST_MUL;
                end
              end
            end
            ACT_CHECK: begin
              if (check_ok) begin
                res_kind <= KIND_RESEND;
                res_seq <= head.seq;
                res_res <= head_res_inc;
              end
            end
            default: ;
          endcase
        end
        ST_MUL: begin
          product <= $signed({1'b0, current_timeout}) * factor;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (sum < 45'sd5) current_timeout <= TIMEOUT_MIN;
          else if (sum > 45'sh0_FFFF_FFFF) current_timeout <= 32'hFFFF_FFFF;
          else current_timeout <= sum[31:0];
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (steps < CW'(WINDOW) && slot_status[base_slot] == SLOT_ACKED) begin
            slot_status[base_slot] <= SLOT_FREE;
            base_seq <= base_seq + 16'd1;
            if (free_slots < CW'(WINDOW)) free_slots <= free_slots + CW'(1);
            steps <= steps + CW'(1);
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            kind <= res_kind;
            tx_seq <= res_seq;
            tx_resends <= res_res;
            base_now <= base_seq;
            in_flight <= 5'(count);
            done_res <= (base_seq >= eff_total);
            timeout_now <= current_timeout;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_flight_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(WINDOW)) else $error("queue overfilled");
  a_timeout_min: assert property (@(posedge clk) disable iff (rst)
    current_timeout >= TIMEOUT_MIN) else $error("timeout below minimum");
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_EXEC) else $error("request not started");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_slots <= CW'(WINDOW)) else $error("free slot count overflow");
endmodule
